@@ src/wss_pkg.sv @@
`default_nettype none

package wss_pkg;

  localparam int unsigned PatternMax = 24;
  localparam int unsigned LenW       = 5;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned DataW      = 64;

  localparam logic [31:0] DispBias = 32'd4;

  localparam logic [2:0] RegPatLow  = 3'd0;
  localparam logic [2:0] RegPatMid  = 3'd1;
  localparam logic [2:0] RegPatHigh = 3'd2;
  localparam logic [2:0] RegMask    = 3'd3;
  localparam logic [2:0] RegLen     = 3'd4;
  localparam logic [2:0] RegOffset  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wss_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] target;
    logic [31:0] match_start;
  } wss_out_t;

endpackage

`default_nettype wire

@@ src/wildcard_signature_scanner_core.sv @@
// Wildcard signature scanner.
// Input channel: one buffer byte per request (in_req_i), with last_byte on
// the final byte of a buffer. Output channel: at most one request per buffer,
// found=1 with target and match_start on the first pattern match, or found=0
// on the last byte when no match was seen. The end of a buffer rearms the
// scanner.
// Throughput: one byte per cycle while in_stall_o is low. The window compare
// is a single parallel stage between the byte window registers and the output
// register, so out_valid_o rises once the deciding byte has passed the window
// registers and then the output register.
// Stall: the output register holds its request while out_stall_i is high;
// one more byte is taken meanwhile, then in_stall_o rises until the
// output register drains.
// Reset: asynchronous, active low; config and control registers return to reset
// values (pattern_len 1, all others 0) and the scanner starts a fresh buffer.
// Configuration: APB port, registers at 8*i, 64-bit data; the user must write
// them only while no bytes are in flight, the core does not enforce this.
`default_nettype none

module wildcard_signature_scanner_core
  import wss_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire wss_in_t            in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output wss_out_t                out_req_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  logic [63:0]     pat_low_q, pat_mid_q, pat_high_q;
  logic [23:0]     mask_q;
  logic [LenW-1:0] len_q, off_q;
  logic [2:0]      reg_idx;

  logic [PatternMax-1:0][7:0] ap_q, ap_d;
  logic [PatternMax-1:0]      am_q, am_d;
  logic                       cfg_ok_q, cfg_ok_d;
  logic [LenW-1:0]            dbase_q, dbase_d;
  logic [LenW-1:0]            lenm1_q, lenm1_d;
  logic [31:0]                tadd_q, tadd_d;
  logic [191:0]               pat_flat;

  logic [PatternMax-1:0][7:0] win_q;
  logic [LenW-1:0]            fill_q;
  logic [31:0]                pos_q;
  logic                       done_q;

  logic        s2_valid_q;
  logic        s2_last_q;
  logic [31:0] s2_pos_q;

  logic        out_valid_q;
  wss_out_t    out_q;

  logic        accept, s2_go, clear, match, emit;
  logic [31:0] disp;
  logic [31:0] pos_base;
  logic [LenW-1:0] fill_base;

  assign reg_idx = paddr[AddrW-1:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_mid_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '0;
      len_q      <= LenW'(1);
      off_q      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegPatLow:  pat_low_q  <= pwdata;
        RegPatMid:  pat_mid_q  <= pwdata;
        RegPatHigh: pat_high_q <= pwdata;
        RegMask:    mask_q     <= pwdata[23:0];
        RegLen:     len_q      <= pwdata[LenW-1:0];
        RegOffset:  off_q      <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegPatLow:  prdata = pat_low_q;
      RegPatMid:  prdata = pat_mid_q;
      RegPatHigh: prdata = pat_high_q;
      RegMask:    prdata = {40'd0, mask_q};
      RegLen:     prdata = {{(DataW-LenW){1'b0}}, len_q};
      RegOffset:  prdata = {{(DataW-LenW){1'b0}}, off_q};
      default:    prdata = '0;
    endcase
  end

  // pattern aligned to window slots: slot j holds pattern byte len-1-j
  assign pat_flat = {pat_high_q, pat_mid_q, pat_low_q};

  always_comb begin
    logic [LenW-1:0] pidx;
    for (int j = 0; j < PatternMax; j++) begin
      pidx  = LenW'(len_q - LenW'(j) - LenW'(1));
      ap_d[j] = '0;
      am_d[j] = 1'b0;
      if ((LenW'(j) < len_q) && (pidx < LenW'(PatternMax))) begin
        ap_d[j] = pat_flat[8*pidx +: 8];
        am_d[j] = mask_q[pidx];
      end
    end
    cfg_ok_d = (len_q != '0) && (len_q <= LenW'(PatternMax)) &&
               ({1'b0, off_q} + 6'd4 <= {1'b0, len_q});
    dbase_d  = LenW'(len_q - off_q - LenW'(1));
    lenm1_d  = LenW'(len_q - LenW'(1));
    tadd_d   = 32'(off_q) + DispBias - 32'(len_q) + 32'd1;
  end

  always_ff @(posedge clk_i) begin
    ap_q     <= ap_d;
    am_q     <= am_d;
    cfg_ok_q <= cfg_ok_d;
    dbase_q  <= dbase_d;
    lenm1_q  <= lenm1_d;
    tadd_q   <= tadd_d;
  end

  // compare stage
  always_comb begin
    logic [LenW-1:0] dsel;
    match = cfg_ok_q && (fill_q >= len_q);
    for (int j = 0; j < PatternMax; j++) begin
      if (am_q[j] && (win_q[j] != ap_q[j])) begin
        match = 1'b0;
      end
    end
    disp = '0;
    for (int k = 0; k < 4; k++) begin
      dsel = LenW'(dbase_q - LenW'(k));
      if (dsel < LenW'(PatternMax)) begin
        disp[8*k +: 8] = win_q[dsel];
      end
    end
  end

  assign s2_go      = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s2_valid_q && !s2_go;
  assign accept     = in_valid_i && !in_stall_o;
  assign clear      = s2_go && s2_last_q;
  assign emit       = !done_q && (match || s2_last_q);
  assign pos_base   = clear ? '0 : pos_q;
  assign fill_base  = clear ? '0 : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pos_q      <= '0;
      done_q     <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s2_go) begin
        done_q <= s2_last_q ? 1'b0 : (done_q | match);
      end
      if (accept) begin
        s2_valid_q <= 1'b1;
        pos_q      <= pos_base + 32'd1;
        fill_q     <= (fill_base < LenW'(PatternMax)) ? LenW'(fill_base + LenW'(1))
                                                     : fill_base;
      end else begin
        if (s2_go) begin
          s2_valid_q <= 1'b0;
        end
        if (clear) begin
          pos_q  <= '0;
          fill_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q     <= {win_q[PatternMax-2:0], in_req_i.data_byte};
      s2_last_q <= in_req_i.last_byte;
      s2_pos_q  <= pos_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= s2_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && emit) begin
      out_q.found       <= match;
      out_q.target      <= match ? (disp + s2_pos_q + tadd_q) : '0;
      out_q.match_start <= match ? (s2_pos_q - 32'(lenm1_q)) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

@@ src/wss_checker.sv @@
`default_nettype none

module wss_checker
  import wss_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire wss_out_t out_req_o
);

  // input side only backs up when the output register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output request");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.found) |->
      (out_req_o.target == '0 && out_req_o.match_start == '0))
    else $error("not-found result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_req_o)))
    else $error("stalled output request changed");

  // no request appears without a byte accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && $past(rst_ni, 2)) |->
      $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an accepted byte");

endmodule

bind wildcard_signature_scanner_core wss_checker u_wss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import wss_pkg::*;
();

  typedef enum logic [1:0] {RowConfig, RowByte, RowMiss} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [63:0] value;
    wss_in_t     req;
  } step_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  wss_in_t          in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  wss_out_t         out_req;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // register mirror
  logic [63:0] pat_lo = '0, pat_mid = '0, pat_hi = '0;
  logic [23:0] cfg_mask = '0;
  int unsigned cfg_len = 1, cfg_off = 0;

  // scanner mirror
  logic [7:0]  win [PatternMax];
  logic [31:0] pos;
  bit          scan_done;
  int unsigned win_fill;

  wss_out_t    pending_scans[$];
  step_row_t   directed[$];
  int unsigned mismatch_count = 0;
  int unsigned random_sent = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  wildcard_signature_scanner_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void add_row(input step_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  function automatic void expect_result(input wss_out_t res);
    pending_scans.insert(pending_scans.size(), res);
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned i);
    logic [191:0] pat_bits;
    pat_bits = {pat_hi, pat_mid, pat_lo};
    return pat_bits[i*8 +: 8];
  endfunction

  function automatic void rearm_scan();
    foreach (win[k]) win[k] = '0;
    pos = '0;
    scan_done = 1'b0;
    win_fill = 0;
  endfunction

  function automatic bit predict_scan(input wss_in_t r, output wss_out_t res);
    logic [31:0] start, disp;
    bit hit;
    res = '0;
    for (int k = PatternMax - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = r.data_byte;
    if (win_fill < PatternMax) win_fill++;
    hit = !scan_done && cfg_len >= 1 && cfg_len <= PatternMax &&
          cfg_off + 4 <= cfg_len && win_fill >= cfg_len;
    for (int i = 0; i < PatternMax; i++)
      if (hit && i < cfg_len && cfg_mask[i] && pat_byte(i) != win[cfg_len-1-i]) hit = 1'b0;
    if (hit) begin
      start = pos - (cfg_len - 1);
      for (int k = 0; k < 4; k++) disp[8*k +: 8] = win[cfg_len - 1 - (cfg_off + k)];
      res.found = 1'b1;
      res.target = disp + start + cfg_off + DispBias;
      res.match_start = start;
      scan_done = 1'b1;
    end
    if (r.last_byte) begin
      if (!hit && !scan_done) begin
        res = '0;
        hit = 1'b1;
      end
      rearm_scan();
    end else begin
      pos++;
    end
    return hit;
  endfunction

  function automatic step_row_t cfg_row(input logic [2:0] idx, input logic [63:0] v);
    step_row_t row;
    row.kind = RowConfig;
    row.reg_idx = idx;
    row.value = v;
    row.req = '0;
    return row;
  endfunction

  function automatic step_row_t byte_row(input row_kind_e kind, input logic [7:0] b,
                                         input logic last_b);
    step_row_t row;
    row.kind = kind;
    row.reg_idx = RegPatLow;
    row.value = '0;
    row.req.data_byte = b;
    row.req.last_byte = last_b;
    return row;
  endfunction

  task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [63:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 3'b000};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
    logic [63:0] masked;
    masked = v;
    case (idx)
      RegPatLow:  pat_lo = v;
      RegPatMid:  pat_mid = v;
      RegPatHigh: pat_hi = v;
      RegMask: begin
        masked = v & 64'hFF_FFFF;
        cfg_mask = masked[23:0];
      end
      RegLen: begin
        masked = v & 64'h1F;
        cfg_len = {27'd0, masked[4:0]};
      end
      RegOffset: begin
        masked = v & 64'h1F;
        cfg_off = {27'd0, masked[4:0]};
      end
      default: ;
    endcase
    apb_cycle(1'b1, idx, v);
    @(negedge clk);
    apb_cycle(1'b0, idx, '0);
    if (prdata !== masked)
      report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, masked));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // wait until every result is out and the pipeline has drained
  task automatic settle(input int unsigned tail);
    in_valid = 1'b0;
    while (pending_scans.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic send_byte(input wss_in_t r, input bit typed_miss);
    wss_out_t res;
    int unsigned gap;
    if (!hold_req && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 2);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left != 0) burst_left--;
    in_req = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (predict_scan(r, res) || typed_miss)
      expect_result(typed_miss ? wss_out_t'('0) : res);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    logic [7:0] buf_bytes [64];
    int unsigned n, at, idx, plants;
    wss_in_t r;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(1, 3);
      1: n = $urandom_range(30, 60);
      default: n = ((cfg_len >= 1 && cfg_len <= PatternMax) ? cfg_len : 8) +
                   $urandom_range(0, 12);
    endcase
    for (int i = 0; i < n; i++) buf_bytes[i] = 8'($urandom);
    plants = ($urandom_range(0, 4) == 0) ? 0 : ($urandom_range(0, 4) == 0) ? 2 : 1;
    if (cfg_len >= 1 && cfg_len <= PatternMax && n >= cfg_len) begin
      repeat (plants) begin
        at = $urandom_range(0, n - cfg_len);
        for (int i = 0; i < cfg_len; i++)
          if (cfg_mask[i] || $urandom_range(0, 1)) buf_bytes[at+i] = pat_byte(i);
        if ($urandom_range(0, 3) == 0) begin
          idx = at + $urandom_range(0, cfg_len - 1);
          buf_bytes[idx] = buf_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.data_byte = buf_bytes[i];
      r.last_byte = (i == n - 1);
      send_byte(r, 1'b0);
      random_sent++;
    end
  endtask

  task automatic cfg_phase(input int unsigned phase);
    logic [63:0] lo, mid, hi;
    logic [23:0] m;
    int unsigned l, o;
    lo = {$urandom, $urandom};
    mid = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    m = ($urandom_range(0, 3) == 0) ? 24'hFF_FFFF : 24'($urandom);
    l = $urandom_range(4, PatternMax);
    o = $urandom_range(0, l - 4);
    case (phase)
      0: begin
        l = PatternMax;
        o = PatternMax - 4;
        m = 24'hFF_FFFF;
      end
      1: begin
        l = 4;
        o = 0;
        m = '0;
        lo = '0;
        mid = '0;
        hi = '0;
      end
      2: begin
        l = PatternMax;
        o = 0;
        m = 24'hFF_FFFF;
        lo = '1;
        mid = '1;
        hi = '1;
      end
      default:
        case ($urandom_range(0, 9))
          0: l = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(PatternMax + 1, 31);
          1: o = $urandom_range(l - 3, 31);
          2: l = $urandom_range(1, 3);
          default: ;
        endcase
    endcase
    cfg_write(RegPatLow, lo);
    cfg_write(RegPatMid, mid);
    cfg_write(RegPatHigh, hi);
    cfg_write(RegMask, {40'($urandom), m});
    cfg_write(RegLen, 64'(l));
    cfg_write(RegOffset, 64'(o));
  endtask

  always @(posedge clk) begin
    wss_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scans.size() == 0) begin
        report_mismatch($sformatf("result with none pending: found %b target %h start %h",
                                  out_req.found, out_req.target, out_req.match_start));
      end else begin
        want = pending_scans.pop_front();
        if (out_req.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", out_req.found, want.found));
        if (out_req.target !== want.target)
          report_mismatch($sformatf("target %h, want %h", out_req.target, want.target));
        if (out_req.match_start !== want.match_start)
          report_mismatch($sformatf("match_start %h, want %h",
                                    out_req.match_start, want.match_start));
      end
    end
  end

  // receiver stall pattern; one long hold on request
  initial begin
    int unsigned left, mode;
    left = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (120) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = (mode == 3) ? $urandom_range(2, 30) : $urandom_range(5, 60);
        end
        left--;
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = 1'b1;
        endcase
      end
    end
  end

  initial begin
    int unsigned phase, goal;
    rearm_scan();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values: length 1 has no room for a displacement
    add_row(byte_row(RowByte, 8'h00, 1'b0));
    add_row(byte_row(RowMiss, 8'hFF, 1'b1));
    add_row(cfg_row(RegPatLow, 64'h0000_0000_EFBE_ADDE));
    add_row(cfg_row(RegPatMid, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(cfg_row(RegPatHigh, 64'h0));
    add_row(cfg_row(RegMask, 64'hF));
    add_row(cfg_row(RegLen, 64'd4));
    add_row(cfg_row(RegOffset, 64'd0));
    // match mid-buffer, trailing bytes ignored
    add_row(byte_row(RowByte, 8'h11, 1'b0));
    add_row(byte_row(RowByte, 8'hDE, 1'b0));
    add_row(byte_row(RowByte, 8'hAD, 1'b0));
    add_row(byte_row(RowByte, 8'hBE, 1'b0));
    add_row(byte_row(RowByte, 8'hEF, 1'b0));
    add_row(byte_row(RowByte, 8'h22, 1'b0));
    add_row(byte_row(RowByte, 8'h33, 1'b1));
    // match on the last byte
    add_row(byte_row(RowByte, 8'hDE, 1'b0));
    add_row(byte_row(RowByte, 8'hAD, 1'b0));
    add_row(byte_row(RowByte, 8'hBE, 1'b0));
    add_row(byte_row(RowByte, 8'hEF, 1'b1));
    // displacement past the window end
    add_row(cfg_row(RegOffset, 64'd1));
    add_row(byte_row(RowByte, 8'hDE, 1'b0));
    add_row(byte_row(RowByte, 8'hAD, 1'b0));
    add_row(byte_row(RowByte, 8'hBE, 1'b0));
    add_row(byte_row(RowMiss, 8'hEF, 1'b1));
    // buffer shorter than the pattern, all wildcards
    add_row(cfg_row(RegOffset, 64'd0));
    add_row(cfg_row(RegMask, 64'h0));
    add_row(byte_row(RowByte, 8'h01, 1'b0));
    add_row(byte_row(RowByte, 8'h02, 1'b0));
    add_row(byte_row(RowMiss, 8'h03, 1'b1));
    // lengths out of range
    add_row(cfg_row(RegLen, 64'd0));
    add_row(byte_row(RowMiss, 8'h7F, 1'b1));
    add_row(cfg_row(RegLen, 64'd31));
    add_row(byte_row(RowMiss, 8'h80, 1'b1));

    foreach (directed[i]) begin
      if (directed[i].kind == RowConfig) begin
        settle(8);
        cfg_write(directed[i].reg_idx, directed[i].value);
      end else begin
        send_byte(directed[i].req, directed[i].kind == RowMiss);
      end
    end

    phase = 0;
    while (random_sent < 1950) begin
      settle(8);
      cfg_phase(phase);
      if (phase == 4) hold_req = 1'b1;
      goal = random_sent + $urandom_range(40, 90);
      while (random_sent < goal) send_buffer();
      phase++;
    end

    settle(20);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wss_pkg.sv
src/wildcard_signature_scanner_core.sv
src/wss_checker.sv
bench/testbench.sv
